// ----- src/dkgu_pkg.sv -----
package dkgu_pkg;

    localparam int NDIM    = 4;
    localparam int DIM_DEF = 4;
    localparam int IN_W    = 256;
    localparam int OUT_W   = 296;

    localparam logic [7:0]  SIGMA_RST  = 8'd96;
    localparam logic [63:0] PNOISE_RST = 64'h0004_0004_0004_0004;
    localparam logic [63:0] MNOISE_RST = 64'h1000_1000_1000_1000;
    localparam logic [31:0] VAR_ONE    = 32'h0001_0000;

    localparam logic [1:0] CFG_SIGMA  = 2'd0;
    localparam logic [1:0] CFG_PNOISE = 2'd1;
    localparam logic [1:0] CFG_MNOISE = 2'd2;

    typedef struct packed {
        logic [31:0] mean;
        logic [31:0] var_v;
        logic        clip;
    } lane_res_t;

endpackage

// ----- src/dkgu_lane.sv -----
module dkgu_lane
    import dkgu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        init_load,
    input  logic [31:0] init_mean,
    input  logic [31:0] obs,
    input  logic [7:0]  sigma,
    input  logic [15:0] q_cfg,
    input  logic [15:0] r_cfg,
    output lane_res_t   res,
    output logic        done
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_GATE = 3'd3;
    localparam logic [2:0] ST_CLIP = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_UPD  = 3'd7;

    logic [2:0]  state_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] mean_reg;
    logic [31:0] var_reg;
    logic        clip_reg;
    logic [31:0] obs_reg;
    logic [32:0] innov_reg;
    logic [32:0] p_reg;
    logic [33:0] pr_reg;
    logic [49:0] sqx_reg;
    logic [26:0] srem_reg;
    logic [24:0] root_reg;
    logic [28:0] gate_reg;
    logic [32:0] mag_reg;
    logic [33:0] rem1_reg;
    logic [32:0] num1_reg;
    logic [33:0] rem2_reg;
    logic [32:0] num2_reg;

    logic [19:0] r_eff;
    logic [32:0] p_sum;
    logic [32:0] p_eff;
    logic [33:0] pr_sum;
    logic [32:0] innov_calc;
    logic [28:0] s_t;
    logic [28:0] s_trial;
    logic        s_ge;
    logic [32:0] gate_prod;
    logic [32:0] mag_abs;
    logic        mag_over;
    logic [65:0] prod1;
    logic [52:0] prod2;
    logic [34:0] t1;
    logic [34:0] t2;
    logic        ge1;
    logic        ge2;
    logic signed [34:0] m_sum;
    logic [31:0] m_sat;
    logic [31:0] v_new;

    always_comb
    begin
        r_eff      = ({r_cfg, 4'b0} == 20'd0) ? 20'd1 : {r_cfg, 4'b0};
        p_sum      = {1'b0, var_reg} + {13'd0, q_cfg, 4'b0};
        p_eff      = (p_sum == 33'd0) ? 33'd1 : p_sum;
        pr_sum     = {1'b0, p_eff} + {14'd0, r_eff};
        innov_calc = {obs_reg[31], obs_reg} - {mean_reg[31], mean_reg};
        s_t        = {srem_reg, sqx_reg[49:48]};
        s_trial    = {2'b00, root_reg, 2'b01};
        s_ge       = (s_t >= s_trial);
        gate_prod  = sigma * root_reg;
        mag_abs    = innov_reg[32] ? (~innov_reg + 33'd1) : innov_reg;
        mag_over   = (mag_abs > {4'd0, gate_reg});
        prod1      = mag_reg * p_reg;
        prod2      = p_reg * r_eff;
        t1         = {rem1_reg, num1_reg[32]};
        t2         = {rem2_reg, num2_reg[32]};
        ge1        = (t1 >= {1'b0, pr_reg});
        ge2        = (t2 >= {1'b0, pr_reg});
        if (innov_reg[32])
        begin
            m_sum = $signed({{3{mean_reg[31]}}, mean_reg}) - $signed({2'b00, num1_reg});
        end
        else
        begin
            m_sum = $signed({{3{mean_reg[31]}}, mean_reg}) + $signed({2'b00, num1_reg});
        end
        if (m_sum > 35'sh0_7FFF_FFFF)
        begin
            m_sat = 32'h7FFF_FFFF;
        end
        else if (m_sum < -35'sh0_8000_0000)
        begin
            m_sat = 32'h8000_0000;
        end
        else
        begin
            m_sat = m_sum[31:0];
        end
        v_new = (num2_reg == 33'd0) ? 32'd1 : num2_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            mean_reg  <= '0;
            var_reg   <= VAR_ONE;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (init_load)
                        begin
                            mean_reg <= init_mean;
                            var_reg  <= VAR_ONE;
                        end
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    cnt_reg   <= 6'd24;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= ST_GATE;
                    end
                end
                ST_GATE: state_reg <= ST_CLIP;
                ST_CLIP: state_reg <= ST_MUL;
                ST_MUL:
                begin
                    cnt_reg   <= 6'd32;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    mean_reg  <= m_sat;
                    var_reg   <= v_new;
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    obs_reg <= obs;
                end
            end
            ST_PREP:
            begin
                p_reg     <= p_eff;
                pr_reg    <= pr_sum;
                sqx_reg   <= {pr_sum, 16'd0};
                srem_reg  <= '0;
                root_reg  <= '0;
                innov_reg <= innov_calc;
            end
            ST_SQRT:
            begin
                sqx_reg <= {sqx_reg[47:0], 2'b00};
                if (s_ge)
                begin
                    srem_reg <= 27'(s_t - s_trial);
                    root_reg <= {root_reg[23:0], 1'b1};
                end
                else
                begin
                    srem_reg <= s_t[26:0];
                    root_reg <= {root_reg[23:0], 1'b0};
                end
            end
            ST_GATE: gate_reg <= gate_prod[32:4];
            ST_CLIP:
            begin
                clip_reg <= mag_over;
                mag_reg  <= mag_over ? {4'd0, gate_reg} : mag_abs;
            end
            ST_MUL:
            begin
                rem1_reg <= {1'b0, prod1[65:33]};
                num1_reg <= prod1[32:0];
                rem2_reg <= {14'd0, prod2[52:33]};
                num2_reg <= prod2[32:0];
            end
            ST_DIV:
            begin
                rem1_reg <= ge1 ? 34'(t1 - {1'b0, pr_reg}) : t1[33:0];
                num1_reg <= {num1_reg[31:0], ge1};
                rem2_reg <= ge2 ? 34'(t2 - {1'b0, pr_reg}) : t2[33:0];
                num2_reg <= {num2_reg[31:0], ge2};
            end
            default:
            begin
            end
        endcase
    end

    assign res.mean  = mean_reg;
    assign res.var_v = var_reg;
    assign res.clip  = clip_reg;
    assign done      = done_reg;

endmodule

// ----- src/dkgu_merge.sv -----
module dkgu_merge
    import dkgu_pkg::*;
#(
    parameter int DIM = DIM_DEF
)
(
    input  lane_res_t        res [NDIM],
    output logic [OUT_W-1:0] result
);

    logic [2:0]  count;
    logic [33:0] trace;

    always_comb
    begin
        count  = '0;
        trace  = '0;
        result = '0;
        for (int d = 0; d < NDIM; d++)
        begin
            if (d < DIM)
            begin
                result[32*d +: 32]       = res[d].mean;
                result[128 + 32*d +: 32] = res[d].var_v;
                count = count + {2'b00, res[d].clip};
                trace = trace + {2'b00, res[d].var_v};
            end
        end
        result[258:256] = count;
        result[292:259] = trace;
    end

endmodule

// ----- src/diagonal_kalman_gated_update_unit.sv -----
// Diagonal Kalman update with innovation gating, one lane per dimension.
// Input stream s_*: one observation frame per request; s_tuser flags a usable
// prior mean, which only the first frame after reset looks at.
// Output stream m_*: one result per frame (posterior means, variances,
// clipped-component count, variance trace).
// Config port: cfg_wen/cfg_index/cfg_data; index 0 gate sigma, 1 process
// noise table, 2 measurement noise table; index 3 is dropped. Write only idle.
// Each lane runs a 25-step square root and a 33-step restoring divider in
// turn. One frame at a time: a new frame is taken once the result has moved
// into the output register.
// Reset: means clear, variances go to 1.0, registers take their defaults and
// the next frame re-initializes the filter.
// Stall: a result waits in the output register while m_tready is low; the
// unit may take and work one more frame, then holds it until the slot frees.
module diagonal_kalman_gated_update_unit
    import dkgu_pkg::*;
#(
    parameter int DIM = DIM_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,  // obs_0, obs_1, obs_2, obs_3, prior_0..prior_3
    input  logic             s_tuser,  // prior_valid
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,  // est_0..3, var_0..3, clip count, var_trace, pad
    input  logic             cfg_wen,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_data
);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RUN  = 2'd1;
    localparam logic [1:0] T_HOLD = 2'd2;

    logic [1:0]       state_reg;
    logic             started_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [7:0]       sigma_reg;
    logic [63:0]      pnoise_reg;
    logic [63:0]      mnoise_reg;

    logic             accept;
    logic             load;
    logic [DIM-1:0]   lane_done;
    lane_res_t        res [NDIM];
    logic [OUT_W-1:0] merged;

    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == T_HOLD) && (!m_tvalid_reg || m_tready);

    for (genvar d = 0; d < NDIM; d++)
    begin : g_lane
        if (d < DIM)
        begin : g_on
            dkgu_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .start     (accept),
                .init_load (!started_reg),
                .init_mean (s_tuser ? s_tdata[128 + 32*d +: 32] : s_tdata[32*d +: 32]),
                .obs       (s_tdata[32*d +: 32]),
                .sigma     (sigma_reg),
                .q_cfg     (pnoise_reg[16*d +: 16]),
                .r_cfg     (mnoise_reg[16*d +: 16]),
                .res       (res[d]),
                .done      (lane_done[d])
            );
        end
        else
        begin : g_off
            assign res[d] = '0;
        end
    end

    dkgu_merge #(
        .DIM (DIM)
    ) u_merge (
        .res    (res),
        .result (merged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_IDLE;
            started_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            sigma_reg    <= SIGMA_RST;
            pnoise_reg   <= PNOISE_RST;
            mnoise_reg   <= MNOISE_RST;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_index)
                    CFG_SIGMA:  sigma_reg  <= cfg_data[7:0];
                    CFG_PNOISE: pnoise_reg <= cfg_data;
                    CFG_MNOISE: mnoise_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                started_reg <= 1'b1;
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= T_RUN;
                    end
                end
                T_RUN:
                begin
                    if (&lane_done)
                    begin
                        state_reg <= T_HOLD;
                    end
                end
                T_HOLD:
                begin
                    if (load)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= merged;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[258:256] <= 3'(DIM)))
        else $error("gated count exceeds lane count");
    a_var_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[159:128] != 32'd0))
        else $error("posterior variance of lane 0 is zero");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("input taken again while a frame is in flight");
    a_started_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(started_reg))
        else $error("filter start flag dropped without reset");
`endif

endmodule
